>>> rtl/core/pufs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pufs_pkg
// Shared types and constants of the PNG Up-filter serializer.
// ----------------------------------------------------------------------------
package pufs_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int BYTE_W    = 8;
  localparam int COL_W     = 14;
  localparam int ROW_W     = 14;
  localparam int WIDTH_W   = 13;
  localparam int HEIGHT_W  = 15;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 15;

  localparam int MAX_HEIGHT = 16384;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // Filter type byte that opens every row (Up).
  localparam logic [BYTE_W-1:0] UP_FILTER_BYTE = 8'd2;

  // Byte position within the bytes that one item causes.
  localparam logic [1:0] PH_FILT = 2'd0;
  localparam logic [1:0] PH_HI   = 2'd1;
  localparam logic [1:0] PH_LO   = 2'd2;

  typedef logic [1:0] phase_t;

  // Item held by the serializing stage.
  typedef struct packed {
    logic [BYTE_W-1:0] hi;
    logic [BYTE_W-1:0] lo;
    logic              first;
    logic              img_end;
  } ser_item_t;

endpackage

>>> rtl/core/pufs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pufs_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// A read and a write of the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module pufs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/png_up_filter_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_up_filter_serializer
// Turns 16-bit RGBA samples in raster order into the PNG Up-filtered byte
// stream: one filter byte per row, then two big-endian difference bytes per
// sample against the same sample of the row above.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall | in_sample[15:0]
//  out     | output    | out_valid/out_stall | out_byte, out_last_of_run,
//          |           |                     | out_end_of_image
//  cfg     | input     | cfg_we              | cfg_index, cfg_wdata
//
// An item gives two bytes on the output, three when it opens a row; the byte-wide
// output register sends them one at a time. Its first byte goes through the input
// stage with line-store read, the serializer and the output register.
// Reset is synchronous and clears counters, valids and registers (width and
// height to 1); the line store is not cleared. A stall on the output backs
// up through the serializer into in_stall.
// ----------------------------------------------------------------------------
module png_up_filter_serializer
  import pufs_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SAMPLE_W-1:0]  in_sample,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    out_byte,
  output logic                 out_last_of_run,
  output logic                 out_end_of_image,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  localparam int STORE_DEPTH = MAX_WIDTH * 4;
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // Configuration
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;

  // Position counters
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  // Input stage
  logic                a_valid_r;
  logic [SAMPLE_W-1:0] a_sample_r;
  logic                a_use_prev_r;
  logic                a_first_r;
  logic                a_img_end_r;

  // Serializer stage
  logic      b_valid_r;
  ser_item_t b_item_r, b_item_nxt;
  phase_t    b_phase_r;

  // Output register
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;
  logic              out_end_r;

  logic                in_acc;
  logic                out_adv;
  logic                b_emit;
  logic                b_done;
  logic                b_ready;
  logic                a_move;
  logic                in_range;
  logic                row_end;
  logic                img_end;
  logic [WIDTH_W-1:0]  eff_width;
  logic [HEIGHT_W-1:0] eff_height;
  logic [COL_W:0]      per_row;
  logic [COL_W:0]      col_inc;
  logic [ROW_W:0]      row_inc;
  logic [ADDR_W-1:0]   store_addr;
  logic [SAMPLE_W-1:0] store_rdata;
  logic [SAMPLE_W-1:0] prev;

  // Handshake chain: output register, serializer, input stage.
  assign out_adv  = !out_valid_r || !out_stall;
  assign b_emit   = b_valid_r && out_adv;
  assign b_done   = b_emit && (b_phase_r == PH_LO);
  assign b_ready  = !b_valid_r || b_done;
  assign a_move   = a_valid_r && b_ready;
  assign in_stall = a_valid_r && !b_ready;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_W'(1);
      height_r <= HEIGHT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the registers to their legal ranges.
  always_comb begin
    if (width_r == '0) begin
      eff_width = WIDTH_W'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      eff_width = WIDTH_W'(MAX_WIDTH);
    end else begin
      eff_width = width_r;
    end
    if (height_r == '0) begin
      eff_height = HEIGHT_W'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      eff_height = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      eff_height = height_r;
    end
  end

  assign per_row  = (COL_W + 1)'({eff_width, 2'b00});
  assign col_inc  = {1'b0, col_r} + 1'b1;
  assign row_inc  = {1'b0, row_r} + 1'b1;
  assign row_end  = (col_inc >= per_row);
  assign img_end  = row_end && ((ROW_W + 1)'(row_inc) >= (ROW_W + 1)'(eff_height));
  assign in_range = (32'(col_r) < STORE_DEPTH);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = img_end ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // The line store is read and rewritten at the same column on accept; the
  // read returns the row above.
  assign store_addr = ADDR_W'(col_r);

  pufs_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH),
    .ADDR_W(ADDR_W)
  ) u_line_store (
    .clk  (clk),
    .we   (in_acc && in_range),
    .waddr(store_addr),
    .wdata(in_sample),
    .re   (in_acc),
    .raddr(store_addr),
    .rdata(store_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_acc) begin
      a_valid_r <= 1'b1;
    end else if (a_move) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_sample_r   <= in_sample;
      a_use_prev_r <= in_range && (row_r != '0);
      a_first_r    <= (col_r == '0);
      a_img_end_r  <= img_end;
    end
  end

  assign prev = a_use_prev_r ? store_rdata : '0;

  always_comb begin
    b_item_nxt.hi      = a_sample_r[15:8] - prev[15:8];
    b_item_nxt.lo      = a_sample_r[7:0] - prev[7:0];
    b_item_nxt.first   = a_first_r;
    b_item_nxt.img_end = a_img_end_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      b_phase_r <= PH_FILT;
    end else if (a_move) begin
      b_valid_r <= 1'b1;
      b_phase_r <= a_first_r ? PH_FILT : PH_HI;
    end else if (b_done) begin
      b_valid_r <= 1'b0;
    end else if (b_emit) begin
      b_phase_r <= b_phase_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_item_r <= b_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_emit) begin
      case (b_phase_r)
        PH_FILT: out_byte_r <= UP_FILTER_BYTE;
        PH_HI:   out_byte_r <= b_item_r.hi;
        default: out_byte_r <= b_item_r.lo;
      endcase
      out_last_r <= (b_phase_r == PH_LO);
      out_end_r  <= (b_phase_r == PH_LO) && b_item_r.img_end;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_last_of_run  = out_last_r;
  assign out_end_of_image = out_end_r;

`ifndef SYNTHESIS
  // The final byte of the image is always the last byte of its item.
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_end_r |-> out_last_r)
    else $error("end_of_image without last_of_run");

  // A filter byte is only produced by an item that opens a row.
  a_filter_first: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && (b_phase_r == PH_FILT) |-> b_item_r.first)
    else $error("filter byte from an item inside a row");

  // With the input stage empty the block never stalls its input.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !a_valid_r |-> !in_stall)
    else $error("input stalled while the input stage is empty");
`endif

endmodule
